// ----- rtl/bfha_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_pkg
// Types and constants used by the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned HeapBytes = 4096;
  localparam int unsigned HeapWords = HeapBytes / 2;
  localparam int unsigned WordW     = 16;
  localparam int unsigned AddrW     = 17;  // byte address with headroom for walk overrun
  localparam int unsigned MaxData   = HeapBytes - 10;
  localparam int unsigned Overhead  = 6;

  localparam logic CfgSplitThreshold = 1'b0;
  localparam logic CfgBlockTag       = 1'b1;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StNoFit      = 3'd1,
    StBadSize    = 3'd2,
    StNotFormat  = 3'd3,
    StRange      = 3'd4,
    StDoubleFree = 3'd5,
    StNotAlloc   = 3'd6
  } status_e;

  typedef struct packed {
    logic        action;
    logic [12:0] req_size;
    logic [12:0] req_offset;
  } req_t;

  typedef struct packed {
    logic [11:0] result_offset;
    status_e     status;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/bfha_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/best_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Boundary-tag best-fit heap in a single-port word RAM, driven by a sequencer.
// ----------------------------------------------------------------------------
// One item is processed at a time. Every heap access goes through the
// single RAM port, so latency is set by the number of RAM accesses.
// An allocate reads every block in the heap, and may split the chosen
// block. The first valid allocate also sweeps the whole 2048-word RAM
// to zero and lays down the first block before the search.
// A free merges the freed block with free blocks backward and forward.
// A finished result sits in an output register, so the next item can be
// taken while it waits.
module best_fit_heap_allocator (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            req_valid_i,
  output logic                 req_stall_o,
  input  wire bfha_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_stall_i,
  output bfha_pkg::rsp_t       rsp_o
);

  localparam int unsigned AW = bfha_pkg::AddrW;
  localparam int unsigned RamAW = $clog2(bfha_pkg::HeapWords);
  localparam logic [AW-1:0] Ovh = AW'(bfha_pkg::Overhead);
  localparam logic [AW-1:0] MaxD = AW'(bfha_pkg::MaxData);

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_CHECK   = 23'd1 << 1,
    S_CLEAR   = 23'd1 << 2,
    S_FIT_RD  = 23'd1 << 3,
    S_FIT_EV  = 23'd1 << 4,
    S_FIT_END = 23'd1 << 5,
    S_SPLIT   = 23'd1 << 6,
    S_TAG_EV  = 23'd1 << 7,
    S_USE_EV  = 23'd1 << 8,
    S_WB_RD   = 23'd1 << 9,
    S_WB_FEV  = 23'd1 << 10,
    S_WB_PEV  = 23'd1 << 11,
    S_MF_RD   = 23'd1 << 12,
    S_MF_BEV  = 23'd1 << 13,
    S_MF_NEV  = 23'd1 << 14,
    S_LINK0   = 23'd1 << 15,
    S_LINK1   = 23'd1 << 16,
    S_LINK2   = 23'd1 << 17,
    S_MK_H    = 23'd1 << 18,
    S_MK_F    = 23'd1 << 19,
    S_MK_W0   = 23'd1 << 20,
    S_MK_W1   = 23'd1 << 21,
    S_DONE    = 23'd1 << 22
  } state_e;

  state_e st_q, st_d, ret_q, ret_d;

  logic [12:0] thr_q, thr_d;
  logic [15:0] tag_q, tag_d;
  logic        fmt_q, fmt_d;
  logic        act_q, act_d;
  logic [12:0] size_q, size_d;
  logic [12:0] off_q, off_d;
  logic [AW-1:0] b_q, b_d, best_q, best_d, lk_b_q, lk_b_d, p_q, p_d, f_q, f_d;
  logic [15:0] bsz_q, bsz_d, lk_sz_q, lk_sz_d, h_q, h_d, sb_q, sb_d;
  logic        mk_used_q, mk_used_d;
  logic [RamAW-1:0] clr_q, clr_d;
  logic [11:0] res_q, res_d;
  bfha_pkg::status_e sts_q, sts_d;
  logic        ovld_q, ovld_d;
  bfha_pkg::rsp_t out_q, out_d;

  logic [AW-1:0] acc_addr;
  logic          acc_we;
  logic [15:0]   acc_wdata;
  logic          acc_oob, rd_oob_q;
  logic [15:0]   ram_rdata, rdat, dsz;
  logic [AW-1:0] dsz_x, nxt, step, surplus_x;
  logic [15:0]   surplus;
  logic          fit_hit;

  bfha_ram #(
    .WIDTH(bfha_pkg::WordW),
    .DEPTH(bfha_pkg::HeapWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (acc_we && !acc_oob),
    .addr_i (acc_addr[RamAW:1]),
    .wdata_i(acc_wdata),
    .rdata_o(ram_rdata)
  );

  assign acc_oob = |acc_addr[AW-1:RamAW+1];
  assign rdat    = rd_oob_q ? 16'h0 : ram_rdata;
  assign dsz     = {rdat[15:1], 1'b0};
  assign dsz_x   = AW'(dsz);
  assign nxt     = b_q + dsz_x + Ovh;
  assign step    = dsz_x + Ovh;
  assign surplus = bsz_q - 16'(size_q);
  assign surplus_x = AW'(surplus);
  assign fit_hit = !rdat[0] && (dsz >= 16'(size_q)) &&
                   ((best_q == '0) || (dsz < bsz_q));

  assign req_stall_o = (st_q != S_IDLE);
  assign rsp_valid_o = ovld_q;
  assign rsp_o       = out_q;

  always_comb begin
    st_d = st_q;  ret_d = ret_q;
    thr_d = thr_q;  tag_d = tag_q;  fmt_d = fmt_q;
    act_d = act_q;  size_d = size_q;  off_d = off_q;
    b_d = b_q;  best_d = best_q;  lk_b_d = lk_b_q;  p_d = p_q;  f_d = f_q;
    bsz_d = bsz_q;  lk_sz_d = lk_sz_q;  h_d = h_q;  sb_d = sb_q;
    mk_used_d = mk_used_q;  clr_d = clr_q;
    res_d = res_q;  sts_d = sts_q;
    ovld_d = ovld_q;  out_d = out_q;
    acc_addr = '0;  acc_we = 1'b0;  acc_wdata = '0;

    if (ovld_q && !rsp_stall_i) begin
      ovld_d = 1'b0;
    end
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfha_pkg::CfgSplitThreshold: thr_d = cfg_wdata_i[12:0];
        bfha_pkg::CfgBlockTag:       tag_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (st_q)
      S_IDLE: begin
        if (req_valid_i) begin
          act_d  = req_i.action;
          size_d = req_i.req_size + 13'(req_i.req_size[0]);
          off_d  = req_i.req_offset;
          res_d  = '0;
          sts_d  = bfha_pkg::StOk;
          st_d   = S_CHECK;
          if (req_i.action == bfha_pkg::ActAlloc &&
              (req_i.req_size == '0 || 16'(req_i.req_size) > 16'(bfha_pkg::MaxData))) begin
            sts_d = bfha_pkg::StBadSize;
          end
        end
      end
      S_CHECK: begin
        if (act_q == bfha_pkg::ActAlloc) begin
          b_d = AW'(2);  best_d = '0;  bsz_d = '0;  clr_d = '0;
          if (sts_q != bfha_pkg::StOk) st_d = S_DONE;
          else if (!fmt_q)             st_d = S_CLEAR;
          else                         st_d = S_FIT_RD;
        end else begin
          if (!fmt_q) begin
            sts_d = bfha_pkg::StNotFormat;  st_d = S_DONE;
          end else if (off_q[0] || off_q < 13'd6 ||
                       off_q > 13'(bfha_pkg::HeapBytes - 6)) begin
            sts_d = bfha_pkg::StRange;  st_d = S_DONE;
          end else begin
            b_d = AW'(off_q) - AW'(4);
            acc_addr = AW'(off_q) - AW'(2);
            st_d = S_TAG_EV;
          end
        end
      end
      S_CLEAR: begin
        acc_addr = AW'({clr_q, 1'b0});
        acc_we   = 1'b1;
        clr_d    = clr_q + 1'b1;
        if (&clr_q) begin
          fmt_d   = 1'b1;
          lk_b_d  = AW'(2);
          lk_sz_d = 16'(bfha_pkg::MaxData);
          ret_d   = S_FIT_RD;
          st_d    = S_LINK0;
        end
      end
      S_FIT_RD: begin
        acc_addr = b_q;
        st_d = S_FIT_EV;
      end
      S_FIT_EV: begin
        if (dsz == '0) begin
          st_d = S_FIT_END;
        end else begin
          if (fit_hit) begin
            best_d = b_q;  bsz_d = dsz;
          end
          b_d = nxt;
          acc_addr = nxt;
        end
      end
      S_FIT_END: begin
        if (best_q == '0) begin
          sts_d = bfha_pkg::StNoFit;  st_d = S_DONE;
        end else begin
          b_d = best_q;
          res_d = 12'(best_q + AW'(4));
          mk_used_d = 1'b1;
          if (surplus > 16'(thr_q) && surplus >= 16'd8) begin
            lk_b_d = best_q;  lk_sz_d = 16'(size_q);
            ret_d = S_SPLIT;  st_d = S_LINK0;
          end else begin
            ret_d = S_DONE;  st_d = S_MK_H;
          end
        end
      end
      S_SPLIT: begin
        lk_b_d  = best_q + AW'(size_q) + Ovh;
        lk_sz_d = 16'(surplus_x - Ovh);
        ret_d   = S_MK_H;
        st_d    = S_LINK0;
      end
      S_TAG_EV: begin
        if (rdat != tag_q) begin
          sts_d = bfha_pkg::StNotAlloc;  st_d = S_DONE;
        end else begin
          acc_addr = b_q;
          st_d = S_USE_EV;
        end
      end
      S_USE_EV: begin
        if (!rdat[0]) begin
          sts_d = bfha_pkg::StDoubleFree;  st_d = S_DONE;
        end else begin
          mk_used_d = 1'b0;
          ret_d = S_WB_RD;  st_d = S_MK_H;
        end
      end
      S_WB_RD: begin
        if (b_q < AW'(4)) begin
          st_d = S_MF_RD;
        end else begin
          acc_addr = b_q - AW'(2);
          st_d = S_WB_FEV;
        end
      end
      S_WB_FEV: begin
        if (dsz == '0 || step > (b_q - AW'(2))) begin
          st_d = S_MF_RD;
        end else begin
          p_d = b_q - step;
          acc_addr = b_q - step;
          st_d = S_WB_PEV;
        end
      end
      S_WB_PEV: begin
        if (rdat[0] || dsz == '0) begin
          st_d = S_MF_RD;
        end else begin
          b_d = p_q;  st_d = S_WB_RD;
        end
      end
      S_MF_RD: begin
        acc_addr = b_q;
        st_d = S_MF_BEV;
      end
      S_MF_BEV: begin
        sb_d = dsz;
        acc_addr = nxt;
        st_d = S_MF_NEV;
      end
      S_MF_NEV: begin
        if (rdat[0] || dsz == '0 ||
            (AW'(sb_q) + dsz_x + Ovh) > MaxD) begin
          st_d = S_DONE;
        end else begin
          lk_b_d  = b_q;
          lk_sz_d = 16'(AW'(sb_q) + dsz_x + Ovh);
          ret_d   = S_MF_RD;
          st_d    = S_LINK0;
        end
      end
      S_LINK0: begin
        acc_addr = lk_b_q;  acc_we = 1'b1;  acc_wdata = lk_sz_q;
        st_d = S_LINK1;
      end
      S_LINK1: begin
        acc_addr = lk_b_q + AW'(2);  acc_we = 1'b1;  acc_wdata = tag_q;
        st_d = S_LINK2;
      end
      S_LINK2: begin
        acc_addr = lk_b_q + AW'(4) + AW'(lk_sz_q);
        acc_we = 1'b1;  acc_wdata = lk_sz_q;
        st_d = ret_q;
      end
      S_MK_H: begin
        acc_addr = b_q;
        // an allocate always ends right after marking
        if (act_q == bfha_pkg::ActAlloc) ret_d = S_DONE;
        st_d = S_MK_F;
      end
      S_MK_F: begin
        h_d = rdat;
        f_d = b_q + AW'(4) + dsz_x;
        acc_addr = b_q + AW'(4) + dsz_x;
        st_d = S_MK_W0;
      end
      S_MK_W0: begin
        sb_d = rdat;  // footer word
        acc_addr = b_q;  acc_we = 1'b1;
        acc_wdata = {h_q[15:1], mk_used_q};
        st_d = S_MK_W1;
      end
      S_MK_W1: begin
        acc_addr = f_q;  acc_we = 1'b1;
        acc_wdata = {sb_q[15:1], mk_used_q};
        st_d = ret_q;
      end
      S_DONE: begin
        if (!ovld_q || !rsp_stall_i) begin
          ovld_d = 1'b1;
          out_d.result_offset = (sts_q == bfha_pkg::StOk) ? res_q : '0;
          out_d.status = sts_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ret_q    <= S_IDLE;
      thr_q    <= 13'd40;
      tag_q    <= '0;
      fmt_q    <= 1'b0;
      ovld_q   <= 1'b0;
      clr_q    <= '0;
      rd_oob_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ret_q    <= ret_d;
      thr_q    <= thr_d;
      tag_q    <= tag_d;
      fmt_q    <= fmt_d;
      ovld_q   <= ovld_d;
      clr_q    <= clr_d;
      rd_oob_q <= acc_oob;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;  size_q <= size_d;  off_q <= off_d;
    b_q <= b_d;  best_q <= best_d;  lk_b_q <= lk_b_d;  p_q <= p_d;  f_q <= f_d;
    bsz_q <= bsz_d;  lk_sz_q <= lk_sz_d;  h_q <= h_d;  sb_q <= sb_d;
    mk_used_q <= mk_used_d;
    res_q <= res_d;  sts_q <= sts_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire
